// ===== design/adaptive_scene_dwell_timer_defines.svh =====
// ----------------------------------------------------------------------------
// Adaptive scene dwell timer assertion macros
// Shared concurrent assertion forms for the dwell timer; clocked on i_clk,
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_SCENE_DWELL_TIMER_DEFINES_SVH
`define ADAPTIVE_SCENE_DWELL_TIMER_DEFINES_SVH

// same-cycle implication
`define ASDT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASDT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/asdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive scene dwell timer package
// Payload types, internal control structs, constants and register helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package asdt_pkg;

    localparam int HistDepthDef = 4;

    localparam logic [7:0] SCENE_NONE = 8'd255;

    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_BEGIN = 1'b1;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] CFG_MIN_BASE   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_IDEAL_BASE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_IDEAL_SPAN = 2'd2;

    localparam logic [14:0] MIN_BASE_LO    = 15'd500;
    localparam logic [14:0] MIN_BASE_HI    = 15'd30000;
    localparam logic [14:0] MIN_BASE_RST   = 15'd5000;
    localparam logic [15:0] IDEAL_BASE_LO  = 16'd1000;
    localparam logic [15:0] IDEAL_BASE_HI  = 16'd60000;
    localparam logic [15:0] IDEAL_BASE_RST = 16'd12000;
    localparam logic [15:0] IDEAL_SPAN_HI  = 16'd60000;
    localparam logic [15:0] IDEAL_SPAN_RST = 16'd12000;

    localparam logic [15:0] MIN_DWELL_RST   = 16'd5000;
    localparam logic [17:0] IDEAL_DWELL_RST = 18'd12000;

    localparam logic [15:0] BPM_LOW   = 16'd1248;
    localparam logic [15:0] BPM_HIGH  = 16'd2912;
    localparam logic [15:0] BPM_SHIFT = 16'd240;
    localparam logic [15:0] LEVEL_MIN = 16'd6554;
    localparam logic [15:0] DYN_MIN   = 16'd3277;
    localparam logic [15:0] Q_ONE     = 16'd32768;

    // shared divider geometry
    localparam int DivW             = 32;
    localparam int DivDsrW          = 17;
    localparam int DivStepsPerCycle = 2;

    localparam logic [DivDsrW-1:0] BPM_REF_DSR = 17'd2080;
    localparam logic [DivDsrW-1:0] FIFTH_DSR   = 17'd5;
    localparam logic [11:0]        FAC_LOW     = 12'd3;
    localparam logic [11:0]        FAC_HIGH    = 12'd7;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [7:0]  scene_id;
        logic [3:0]  mood_class;
        logic [15:0] tempo_bpm;
        logic [15:0] energy_level;
        logic [15:0] dynamics_level;
    } t_in_item;

    typedef struct packed {
        logic        transition_due;
        logic [31:0] elapsed_ms;
        logic [15:0] min_dwell_ms;
        logic [17:0] ideal_dwell_ms;
        logic [31:0] change_count;
        logic [7:0]  previous_scene;
    } t_out_item;

    typedef struct packed {
        logic [14:0] min_base;
        logic [15:0] ideal_base;
        logic [15:0] ideal_span;
    } t_cfg_regs;

    typedef struct packed {
        logic [15:0] bpm;
        logic [15:0] level;
        logic [15:0] dyn;
    } t_snap;

    typedef struct packed {
        logic               start;
        logic [DivW-1:0]    dividend;
        logic [DivDsrW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        done;
        logic [15:0] min_dwell;
        logic [17:0] ideal_dwell;
    } t_calc_stat;

    function automatic logic [14:0] sat_min_base(input logic [CfgDataW-1:0] v);
        logic [14:0] x;
        x = v[14:0];
        if (x < MIN_BASE_LO) return MIN_BASE_LO;
        if (x > MIN_BASE_HI) return MIN_BASE_HI;
        return x;
    endfunction

    function automatic logic [15:0] sat_ideal_base(input logic [CfgDataW-1:0] v);
        if (v < IDEAL_BASE_LO) return IDEAL_BASE_LO;
        if (v > IDEAL_BASE_HI) return IDEAL_BASE_HI;
        return v;
    endfunction

    function automatic logic [15:0] sat_ideal_span(input logic [CfgDataW-1:0] v);
        if (v > IDEAL_SPAN_HI) return IDEAL_SPAN_HI;
        return v;
    endfunction

    function automatic logic [15:0] clamp_q(input logic [15:0] v,
                                            input logic [15:0] lo);
        if (v < lo) return lo;
        if (v > Q_ONE) return Q_ONE;
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/asdt_div.sv =====
// ----------------------------------------------------------------------------
// Shared serial divider
// Restoring unsigned divider, two quotient bits per cycle, one request at a
// time; a new start restarts it.
// ----------------------------------------------------------------------------
`default_nettype none

module asdt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asdt_pkg::t_div_req i_req,
    output asdt_pkg::t_div_rsp o_rsp
);
    import asdt_pkg::*;

    localparam int Cycles = DivW / DivStepsPerCycle;
    localparam int CntW   = $clog2(Cycles);

    logic                r_run;
    logic                r_done;
    logic [CntW-1:0]     r_cnt;
    logic [DivDsrW-1:0]  r_rem;
    logic [DivW-1:0]     r_quo;
    logic [DivDsrW-1:0]  r_dsr;
    logic [DivDsrW-1:0]  n_rem;
    logic [DivW-1:0]     n_quo;
    logic [DivDsrW:0]    trial;
    logic [DivDsrW:0]    diff;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        diff  = '0;
        for (int k = 0; k < DivStepsPerCycle; k++) begin
            trial = {n_rem, n_quo[DivW-1]};
            n_quo = {n_quo[DivW-2:0], 1'b0};
            diff  = trial - {1'b0, r_dsr};
            if (trial >= {1'b0, r_dsr}) begin
                n_rem    = diff[DivDsrW-1:0];
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[DivDsrW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(Cycles - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

// ===== design/asdt_calc.sv =====
// ----------------------------------------------------------------------------
// Dwell duration sequencer
// Recomputes minimum and ideal dwell from the settings and the stored mood
// snapshot: one multiply, then two passes through the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module asdt_calc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  asdt_pkg::t_cfg_regs  i_cfg,
    input  asdt_pkg::t_snap      i_snap,
    output asdt_pkg::t_calc_stat o_stat
);
    import asdt_pkg::*;

    localparam logic [2:0] C_IDLE   = 3'd0;
    localparam logic [2:0] C_MUL    = 3'd1;
    localparam logic [2:0] C_MSTART = 3'd2;
    localparam logic [2:0] C_MWAIT  = 3'd3;
    localparam logic [2:0] C_IWAIT  = 3'd4;

    logic [2:0]          r_state;
    logic                r_done;
    logic [15:0]         r_min;
    logic [17:0]         r_ideal;
    logic [26:0]         r_prod;
    logic [DivDsrW-1:0]  r_mdsr;

    logic [11:0]         mfac;
    logic [DivDsrW-1:0]  mdsr;
    logic [26:0]         prod;
    logic [15:0]         lvl_c;
    logic [15:0]         dyn_c;
    logic [DivDsrW-1:0]  qsum;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    // tempo factor: clamp to 3/5 and 7/5 outside the tracking band
    always_comb begin
        if (i_snap.bpm < BPM_LOW) begin
            mfac = FAC_LOW;
            mdsr = FIFTH_DSR;
        end else if (i_snap.bpm > BPM_HIGH) begin
            mfac = FAC_HIGH;
            mdsr = FIFTH_DSR;
        end else begin
            mfac = i_snap.bpm[11:0];
            mdsr = BPM_REF_DSR;
        end
    end

    assign prod  = 27'(i_cfg.min_base) * 27'(mfac);
    assign lvl_c = clamp_q(i_snap.level, LEVEL_MIN);
    assign dyn_c = clamp_q(i_snap.dyn, DYN_MIN);
    assign qsum  = {1'b0, lvl_c} + {1'b0, dyn_c};

    always_comb begin
        div_req.start    = (r_state == C_MSTART) || (r_state == C_MWAIT && div_rsp.done);
        div_req.dividend = {1'b0, i_cfg.ideal_span, 15'd0};
        div_req.divisor  = qsum;
        if (r_state == C_MSTART) begin
            div_req.dividend = {5'd0, r_prod};
            div_req.divisor  = r_mdsr;
        end
    end

    asdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_min   <= MIN_DWELL_RST;
            r_ideal <= IDEAL_DWELL_RST;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_state <= C_MUL;
            end else begin
                case (r_state)
                    C_MUL: begin
                        r_state <= C_MSTART;
                    end
                    C_MSTART: begin
                        r_state <= C_MWAIT;
                    end
                    C_MWAIT: begin
                        if (div_rsp.done) begin
                            r_min   <= div_rsp.quo[15:0];
                            r_state <= C_IWAIT;
                        end
                    end
                    C_IWAIT: begin
                        if (div_rsp.done) begin
                            r_ideal <= {2'd0, i_cfg.ideal_base} + div_rsp.quo[17:0];
                            r_done  <= 1'b1;
                            r_state <= C_IDLE;
                        end
                    end
                    default: begin
                        r_state <= C_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_MUL) begin
            r_prod <= prod;
            r_mdsr <= mdsr;
        end
    end

    assign o_stat.done        = r_done;
    assign o_stat.min_dwell   = r_min;
    assign o_stat.ideal_dwell = r_ideal;

endmodule

`default_nettype wire

// ===== design/adaptive_scene_dwell_timer.sv =====
// ----------------------------------------------------------------------------
// Adaptive scene dwell timer
// Tracks the running scene and decides when a scene change is due.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid/o_in_ready with a t_in_item payload; every
//   request yields one result on o_out_valid/i_out_ready (t_out_item).
//   A check request is answered from the stored scene state: the result is
//   registered on acceptance, and the next request may follow right away.
//   A begin request updates the scene state and recomputes both dwell times:
//   a multiply step, then two passes through the shared two-bit-per-cycle
//   divider (minimum dwell, then ideal dwell), then the result is loaded;
//   o_in_ready stays low meanwhile. A write on the configuration port also
//   recomputes the dwell times and holds o_in_ready low until it finishes,
//   without producing a result.
//   The result register frees the input side as soon as it is taken; while
//   the receiver stalls, the pending result holds and o_in_ready stays low.
//   Reset (synchronous, active low) restores default settings, the default
//   dwell times, an empty history and no active scene.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adaptive_scene_dwell_timer_defines.svh"

module adaptive_scene_dwell_timer #(
    parameter int HISTORY_DEPTH = asdt_pkg::HistDepthDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  asdt_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output asdt_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [asdt_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [asdt_pkg::CfgDataW-1:0]   i_cfg_data
);
    import asdt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]   r_state;
    logic         r_is_begin;
    logic         r_out_valid;
    t_out_item    r_out;
    t_cfg_regs    r_cfg;
    t_snap        r_snap;
    logic         r_active;
    logic [7:0]   r_cur;
    logic [31:0]  r_start;
    logic [3:0]   r_mood;
    logic [31:0]  r_count;
    logic [7:0]   r_hist [HISTORY_DEPTH];

    logic         in_acc;
    logic         out_free;
    logic         begin_acc;
    logic         check_acc;
    logic         cfg_hit;
    logic         calc_start;
    t_calc_stat   calc_stat;
    logic [31:0]  elapsed;
    logic [15:0]  bpm_diff;
    logic         due;
    t_out_item    check_out;
    t_out_item    begin_out;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign begin_acc  = in_acc && (i_in_data.action == ACT_BEGIN);
    assign check_acc  = in_acc && (i_in_data.action == ACT_CHECK);
    assign cfg_hit    = i_cfg_we && ((i_cfg_idx == CFG_MIN_BASE) ||
                                     (i_cfg_idx == CFG_IDEAL_BASE) ||
                                     (i_cfg_idx == CFG_IDEAL_SPAN));
    assign calc_start = begin_acc || cfg_hit;

    asdt_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (calc_start),
        .i_cfg   (r_cfg),
        .i_snap  (r_snap),
        .o_stat  (calc_stat)
    );

    // check verdict and begin result
    always_comb begin
        elapsed  = i_in_data.now_ms - r_start;
        bpm_diff = (i_in_data.tempo_bpm > r_snap.bpm) ? i_in_data.tempo_bpm - r_snap.bpm
                                                      : r_snap.bpm - i_in_data.tempo_bpm;
        due = (elapsed > {16'd0, calc_stat.min_dwell}) &&
              ((i_in_data.mood_class != r_mood) || (bpm_diff > BPM_SHIFT) ||
               (elapsed > {14'd0, calc_stat.ideal_dwell}));

        check_out.transition_due = due;
        check_out.elapsed_ms     = elapsed;
        check_out.min_dwell_ms   = calc_stat.min_dwell;
        check_out.ideal_dwell_ms = calc_stat.ideal_dwell;
        check_out.change_count   = r_count;
        check_out.previous_scene = r_hist[0];

        begin_out.transition_due = 1'b0;
        begin_out.elapsed_ms     = '0;
        begin_out.min_dwell_ms   = calc_stat.min_dwell;
        begin_out.ideal_dwell_ms = calc_stat.ideal_dwell;
        begin_out.change_count   = r_count;
        begin_out.previous_scene = r_hist[0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_is_begin <= 1'b0;
        end else begin
            if (begin_acc) begin
                r_is_begin <= 1'b1;
            end else if (cfg_hit && r_state == ST_IDLE) begin
                r_is_begin <= 1'b0;
            end
            if (calc_start) begin
                r_state <= ST_CALC;
            end else begin
                case (r_state)
                    ST_CALC: begin
                        if (calc_stat.done) begin
                            r_state <= r_is_begin ? ST_EMIT : ST_IDLE;
                        end
                    end
                    ST_EMIT: begin
                        if (out_free) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (check_acc || (r_state == ST_EMIT && out_free && !calc_start)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (check_acc) begin
            r_out <= check_out;
        end else if (r_state == ST_EMIT && out_free && !calc_start) begin
            r_out <= begin_out;
        end
    end

    // settings, saturated on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_base   <= MIN_BASE_RST;
            r_cfg.ideal_base <= IDEAL_BASE_RST;
            r_cfg.ideal_span <= IDEAL_SPAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_BASE:   r_cfg.min_base   <= sat_min_base(i_cfg_data);
                CFG_IDEAL_BASE: r_cfg.ideal_base <= sat_ideal_base(i_cfg_data);
                CFG_IDEAL_SPAN: r_cfg.ideal_span <= sat_ideal_span(i_cfg_data);
                default: ;
            endcase
        end
    end

    // scene state and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cur    <= SCENE_NONE;
            r_start  <= '0;
            r_mood   <= '0;
            r_snap   <= '0;
            r_count  <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= SCENE_NONE;
            end
        end else if (begin_acc) begin
            // push the outgoing scene only when a scene is active and the id changes
            if (r_active && r_cur != i_in_data.scene_id) begin
                for (int i = 1; i < HISTORY_DEPTH; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= r_cur;
            end
            r_active     <= 1'b1;
            r_cur        <= i_in_data.scene_id;
            r_start      <= i_in_data.now_ms;
            r_mood       <= i_in_data.mood_class;
            r_snap.bpm   <= i_in_data.tempo_bpm;
            r_snap.level <= i_in_data.energy_level;
            r_snap.dyn   <= i_in_data.dynamics_level;
            r_count      <= r_count + 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASDT_ASSERT_NXT(a_begin_recompute, begin_acc, r_state == ST_CALC, "begin request did not start recompute")
    `ASDT_ASSERT_IMP(a_done_in_calc, calc_stat.done, r_state == ST_CALC, "recompute finished outside calc state")
    `ASDT_ASSERT_NXT(a_check_result, check_acc, r_out_valid, "check request produced no result")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adaptive scene dwell timer testbench
// Drives begin and check requests through the valid/ready input channel,
// programs the dwell registers between traffic phases, and compares every
// result field against a cycle-free software predictor of the timer.
// ----------------------------------------------------------------------------

module tb_top;

    import asdt_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int RECALC_WAIT     = 80;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int CFG_PHASES      = 6;
    localparam int HIST_DEPTH      = HistDepthDef;

    localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

    // tempo is u12.4: 130 bpm reference, 78 / 182 bpm clamp points, 15 bpm shift
    localparam int unsigned TEMPO_REF   = 2080;
    localparam int unsigned TEMPO_LOW   = 1248;
    localparam int unsigned TEMPO_HIGH  = 2912;
    localparam int unsigned TEMPO_SHIFT = 240;
    localparam int unsigned LEVEL_FLOOR = 6554;
    localparam int unsigned DYN_FLOOR   = 3277;
    localparam int unsigned UNITY_Q15   = 32768;

    // fixed register settings; the last phase uses random values
    localparam logic [15:0] CFG_PLAN [CFG_PHASES-1][3] = '{
        '{16'd0,     16'd0,     16'd0},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF},
        '{16'd500,   16'd1000,  16'd60000},
        '{16'd30000, 16'd60000, 16'd0},
        '{16'h84D2,  16'd999,   16'd60001}
    };

    class scene_timer_tracker;
        int unsigned    min_base;
        int unsigned    ideal_base;
        int unsigned    ideal_span;
        bit             active;
        logic [7:0]     cur_scene;
        logic [31:0]    start_ms;
        logic [3:0]     start_mood;
        logic [15:0]    snap_bpm;
        logic [15:0]    snap_level;
        logic [15:0]    snap_dyn;
        logic [15:0]    min_dwell;
        logic [17:0]    ideal_dwell;
        logic [31:0]    begun;
        logic [7:0]     history [HIST_DEPTH];
        t_out_item      pending [$];
        int unsigned    mismatches;
        int unsigned    compared;
        int unsigned    begins;
        int unsigned    checks;
        int unsigned    transitions;

        function new();
            min_base    = 5000;
            ideal_base  = 12000;
            ideal_span  = 12000;
            active      = 1'b0;
            cur_scene   = SCENE_NONE;
            start_ms    = '0;
            start_mood  = '0;
            snap_bpm    = '0;
            snap_level  = '0;
            snap_dyn    = '0;
            min_dwell   = 16'd5000;
            ideal_dwell = 18'd12000;
            begun       = '0;
            foreach (history[i]) history[i] = SCENE_NONE;
        endfunction

        function void refresh_dwells();
            longint unsigned m;
            longint unsigned e;
            longint unsigned d;
            if (snap_bpm < TEMPO_LOW) begin
                m = (longint'(min_base) * 3) / 5;
            end else if (snap_bpm > TEMPO_HIGH) begin
                m = (longint'(min_base) * 7) / 5;
            end else begin
                m = (longint'(min_base) * snap_bpm) / TEMPO_REF;
            end
            min_dwell = 16'(m);
            e = (snap_level < LEVEL_FLOOR) ? LEVEL_FLOOR :
                (snap_level > UNITY_Q15) ? UNITY_Q15 : snap_level;
            d = (snap_dyn < DYN_FLOOR) ? DYN_FLOOR :
                (snap_dyn > UNITY_Q15) ? UNITY_Q15 : snap_dyn;
            ideal_dwell = 18'(ideal_base + (longint'(ideal_span) * UNITY_Q15) / (e + d));
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            int unsigned v;
            case (idx)
                CFG_MIN_BASE: begin
                    v = data[14:0];
                    min_base = (v < 500) ? 500 : (v > 30000) ? 30000 : v;
                end
                CFG_IDEAL_BASE: begin
                    v = data;
                    ideal_base = (v < 1000) ? 1000 : (v > 60000) ? 60000 : v;
                end
                CFG_IDEAL_SPAN: begin
                    v = data;
                    ideal_span = (v > 60000) ? 60000 : v;
                end
                default: return;
            endcase
            refresh_dwells();
        endfunction

        function void note_request(t_in_item rq);
            t_out_item   r;
            logic [31:0] gap;
            logic [15:0] drift;
            r = '0;
            if (rq.action == ACT_BEGIN) begin
                if (active && cur_scene != rq.scene_id) begin
                    for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
                    history[0] = cur_scene;
                end
                active     = 1'b1;
                cur_scene  = rq.scene_id;
                start_ms   = rq.now_ms;
                start_mood = rq.mood_class;
                snap_bpm   = rq.tempo_bpm;
                snap_level = rq.energy_level;
                snap_dyn   = rq.dynamics_level;
                refresh_dwells();
                begun = begun + 1;
                begins++;
            end else begin
                gap   = rq.now_ms - start_ms;
                drift = (rq.tempo_bpm > snap_bpm) ? rq.tempo_bpm - snap_bpm
                                                  : snap_bpm - rq.tempo_bpm;
                r.transition_due = (gap > min_dwell) &&
                    (rq.mood_class != start_mood || drift > TEMPO_SHIFT || gap > ideal_dwell);
                r.elapsed_ms = gap;
                checks++;
            end
            r.min_dwell_ms   = min_dwell;
            r.ideal_dwell_ms = ideal_dwell;
            r.change_count   = begun;
            r.previous_scene = history[0];
            pending.push_back(r);
        endfunction

        function string show(t_out_item r);
            return $sformatf("due=%0d elapsed=%0d min=%0d ideal=%0d count=%0d prev=%0d",
                             r.transition_due, r.elapsed_ms, r.min_dwell_ms,
                             r.ideal_dwell_ms, r.change_count, r.previous_scene);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            compared++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing outstanding: %s", show(got));
                return;
            end
            want = pending.pop_front();
            if (want.transition_due) transitions++;
            if (got.transition_due !== want.transition_due ||
                got.elapsed_ms     !== want.elapsed_ms     ||
                got.min_dwell_ms   !== want.min_dwell_ms   ||
                got.ideal_dwell_ms !== want.ideal_dwell_ms ||
                got.change_count   !== want.change_count   ||
                got.previous_scene !== want.previous_scene) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d expected %s", compared, show(want));
                    $display("       result %0d got      %s", compared, show(got));
                end
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_idx   = '0;
    logic [CfgDataW-1:0]  i_cfg_data  = '0;

    scene_timer_tracker   tracker;
    int                   cycles      = 0;
    int                   burst_left  = 0;
    int                   settings    = 0;
    logic [31:0]          wall_ms     = '0;
    int                   ready_mode  = 0;
    int                   ready_hold  = 0;
    logic [2:0]           ready_tick  = '0;

    adaptive_scene_dwell_timer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // receiver: switch between always ready, random stalls and a fixed duty pattern
    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_hold <= $urandom_range(40, 300);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        ready_tick <= ready_tick + 3'd1;
        case (ready_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= (ready_tick < 3'd3);
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_result(o_out_data);
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("adaptive_scene_dwell_timer: mismatch");
            $finish;
        end
    end

    // hold the request until accepted; bursts of back-to-back requests with idle gaps
    task automatic push_request(input t_in_item rq);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(60, 200);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 10);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= rq;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(rq);
    endtask

    task automatic req(input logic act, input logic [31:0] now, input logic [7:0] sid,
                       input logic [3:0] mood, input logic [15:0] bpm,
                       input logic [15:0] lvl, input logic [15:0] dyn);
        t_in_item rq;
        rq.action         = act;
        rq.now_ms         = now;
        rq.scene_id       = sid;
        rq.mood_class     = mood;
        rq.tempo_bpm      = bpm;
        rq.energy_level   = lvl;
        rq.dynamics_level = dyn;
        push_request(rq);
    endtask

    task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        // let the dwell recompute finish before anything else
        repeat (RECALC_WAIT) @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (RECALC_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 6600));
            1:       return 16'($urandom_range(0, 32768));
            2:       return 16'd32768;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        int unsigned lo;
        int unsigned hi;
        lo = tracker.min_dwell;
        hi = tracker.ideal_dwell;
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, lo + 100);
            1:       return lo - 1 + $urandom_range(0, 2);
            2:       return hi - 1 + $urandom_range(0, 2);
            3:       return $urandom_range(lo, hi + 2000);
            4:       return $urandom_range(0, 2 * hi);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_tempo(input logic [15:0] base);
        case ($urandom_range(0, 4))
            0:       return base;
            1:       return $urandom_range(0, 1) ? 16'(base + TEMPO_SHIFT)
                                                 : 16'(base - TEMPO_SHIFT);
            2:       return $urandom_range(0, 1) ? 16'(base + TEMPO_SHIFT + 1)
                                                 : 16'(base - TEMPO_SHIFT - 1);
            3:       return 16'(base + $urandom_range(0, 600) - 300);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic directed();
        // checks against the reset state, before any scene exists
        req(ACT_CHECK, 32'd0,         8'd0, 4'd0,  16'd0,     16'd0, 16'd0);
        req(ACT_CHECK, 32'd5001,      8'd0, 4'd0,  16'd0,     16'd0, 16'd0);
        req(ACT_CHECK, 32'd5001,      8'd0, 4'd3,  16'd0,     16'd0, 16'd0);
        req(ACT_CHECK, 32'd12001,     8'd0, 4'd0,  16'd0,     16'd0, 16'd0);
        req(ACT_CHECK, 32'hFFFF_FFFF, 8'hFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // first begin: floor clamps, time about to wrap
        req(ACT_BEGIN, 32'hFFFF_FF00, 8'd7, 4'd5,  16'd0,     16'd0, 16'd0);
        req(ACT_CHECK, 32'h0000_0100, 8'd0, 4'd9,  16'd0,     16'd0, 16'd0);
        // same scene again, then tempo and level clamp edges
        req(ACT_BEGIN, 32'd10,        8'd7, 4'd5,  16'd1247,  16'hFFFF, 16'hFFFF);
        req(ACT_BEGIN, 32'd20,        8'd9, 4'd1,  16'd1248,  16'd32768, 16'd32768);
        req(ACT_BEGIN, 32'd30,        8'hFF, 4'd1, 16'd2912,  16'd32769, 16'd3276);
        req(ACT_BEGIN, 32'd40,        8'd254, 4'd1, 16'd2913, 16'd6553, 16'd3277);
        req(ACT_BEGIN, 32'd1000,      8'd0, 4'hF,  16'hFFFF,  16'd6554, 16'd32767);
        // nominal scene: min 5000, ideal 24000 under reset settings
        req(ACT_BEGIN, 32'd2000,      8'd1, 4'd2,  16'd2080,  16'd16384, 16'd16384);
        req(ACT_CHECK, 32'd7000,      8'd0, 4'd3,  16'd2080,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd7001,      8'd0, 4'd3,  16'd2080,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd7001,      8'd0, 4'd2,  16'd2320,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd7001,      8'd0, 4'd2,  16'd2321,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd7001,      8'd0, 4'd2,  16'd1839,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd7001,      8'd0, 4'd2,  16'd1840,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd26000,     8'd0, 4'd2,  16'd2080,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd26001,     8'd0, 4'd2,  16'd2080,  16'd0, 16'd0);
        req(ACT_CHECK, 32'd1999,      8'd0, 4'd2,  16'd2080,  16'd0, 16'd0);
    endtask

    // mostly begin-then-checks scenes with probing time offsets; some raw noise
    task automatic run_scenes(input int count);
        int          sent;
        logic [31:0] t0;
        logic [31:0] offs;
        logic [7:0]  sid;
        logic [3:0]  mood0;
        logic [15:0] bpm0;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                req(1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)),
                    4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                sent++;
            end else begin
                t0    = ($urandom_range(0, 3) == 0) ? $urandom
                                                    : wall_ms + $urandom_range(0, 50000);
                sid   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 5));
                mood0 = 4'($urandom_range(0, 15));
                bpm0  = $urandom_range(0, 1) ? 16'($urandom_range(1000, 3200))
                                             : 16'($urandom_range(0, 65535));
                req(ACT_BEGIN, t0, sid, mood0, bpm0, pick_level(), pick_level());
                sent++;
                offs = '0;
                repeat ($urandom_range(0, 6)) begin
                    offs = pick_offset();
                    req(ACT_CHECK, t0 + offs, 8'($urandom_range(0, 255)),
                        ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : mood0,
                        pick_tempo(bpm0), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
                    sent++;
                end
                wall_ms = t0 + offs;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();
        run_scenes(ITEMS_PER_PHASE);
        settings = 1;

        for (int p = 0; p < CFG_PHASES; p++) begin
            settle();
            if (p == CFG_PHASES - 1) begin
                set_reg(CFG_MIN_BASE,   16'($urandom_range(0, 65535)));
                set_reg(CFG_IDEAL_BASE, 16'($urandom_range(0, 65535)));
                set_reg(CFG_IDEAL_SPAN, 16'($urandom_range(0, 65535)));
            end else begin
                set_reg(CFG_MIN_BASE,   CFG_PLAN[p][0]);
                set_reg(CFG_IDEAL_BASE, CFG_PLAN[p][1]);
                set_reg(CFG_IDEAL_SPAN, CFG_PLAN[p][2]);
            end
            set_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
            settings++;
            run_scenes(ITEMS_PER_PHASE);
        end
        settle();

        $display("run covered %0d requests (%0d scene begins, %0d checks, %0d transitions due)",
                 tracker.begins + tracker.checks, tracker.begins, tracker.checks,
                 tracker.transitions);
        $display("across %0d register settings; %0d results compared, %0d mismatches",
                 settings, tracker.compared, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("adaptive_scene_dwell_timer: match");
        end else begin
            $display("adaptive_scene_dwell_timer: mismatch");
        end
        $finish;
    end

endmodule

// ===== adaptive_scene_dwell_timer.f =====
+incdir+design
design/asdt_pkg.sv
design/asdt_div.sv
design/asdt_calc.sv
design/adaptive_scene_dwell_timer.sv
bench/tb_top.sv
